// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/htfe_pkg.sv =====
// ----------------------------------------------------------------------------
// htfe_pkg
// Types and constants of the head/tail frame extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htfe_pkg;

	localparam int BYTE_W    = 8;
	localparam int TAIL_W    = 32;
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN = 2'd1;

	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h88;
	localparam logic [TAIL_W-1:0] TAIL_RESET = 32'h55AA_55AA;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/head_tail_frame_extractor.sv =====
// A byte that does not close a frame is taken without a stall. A byte that
// closes a frame moves the block through S_READ to S_OUT, which gives one byte
// per cycle while out_stall is low. Input stalls until the last byte is taken;
// the ring has one read port. An overlong frame gives its one result in the
// cycle after the closing byte. Reset clears all control state and sets
// head_byte to 0x88 and tail_pattern to 0x55AA55AA; ring contents are undefined.
// ----------------------------------------------------------------------------
// head_tail_frame_extractor
// Writes received bytes into a ring and emits each head/tail delimited frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module head_tail_frame_extractor #(
	parameter int BUFFER_BYTES = 64,
	parameter int TAIL_BYTES   = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [htfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [htfe_pkg::CFG_W-1:0]      cfg_data,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [htfe_pkg::BYTE_W-1:0]     rx_byte,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [htfe_pkg::BYTE_W-1:0]          frame_byte,
	output logic                                 last_of_frame,
	output logic [htfe_pkg::LEN_W-1:0]           frame_length,
	output logic                                 too_long
);

	import htfe_pkg::*;

	localparam int PW  = $clog2(BUFFER_BYTES);
	localparam int CW  = $clog2(BUFFER_BYTES + 2);
	localparam int TMW = (TAIL_BYTES > 1) ? $clog2(TAIL_BYTES) : 1;

	// configuration registers
	logic [BYTE_W-1:0] head_byte_q;
	logic [TAIL_W-1:0] tail_pattern_q;

	// frame tracking
	logic [PW-1:0]  wp_q;
	logic           open_q;
	logic [PW-1:0]  start_q;
	logic [TMW-1:0] tmatch_q;
	logic [CW-1:0]  nbytes_q;

	// emission
	state_t         state_q, state_d;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  emit_idx_q;
	logic [CW-1:0]  len_q;
	logic           long_q;
	logic [BYTE_W-1:0] rd_data_q;

	logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];

	logic              in_acc;
	logic              out_acc;
	logic [TAIL_W-1:0] tail_shift;
	logic              tail_hit;
	logic              close_hit;
	logic [CW-1:0]     nbytes_nx;
	logic              over;
	logic              last_w;
	logic              rd_en;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_acc  = in_valid & ~in_stall;
	assign out_acc = out_valid & ~out_stall;

	// expected tail byte sits in the top byte after shifting out matched ones
	assign tail_shift = tail_pattern_q << {tmatch_q, 3'b000};
	assign tail_hit   = (rx_byte == tail_shift[TAIL_W-1 -: BYTE_W]);
	assign close_hit  = open_q & tail_hit & (tmatch_q == TMW'(TAIL_BYTES - 1));
	assign nbytes_nx  = (nbytes_q <= CW'(BUFFER_BYTES)) ? nbytes_q + 1'b1 : nbytes_q;
	assign over       = (nbytes_nx > CW'(BUFFER_BYTES));

	assign last_w        = long_q | (emit_idx_q == len_q - CW'(1));
	assign frame_byte    = long_q ? '0 : rd_data_q;
	assign last_of_frame = last_w;
	assign frame_length  = long_q ? '0 : LEN_W'(len_q);
	assign too_long      = long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_byte_q    <= HEAD_RESET;
			tail_pattern_q <= TAIL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAD_BYTE:    head_byte_q    <= cfg_data[BYTE_W-1:0];
				REG_TAIL_PATTERN: tail_pattern_q <= cfg_data[TAIL_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && close_hit) begin
					state_d = over ? S_OUT : S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (last_w) begin
						state_d = S_IDLE;
					end else begin
						// fetch the next byte behind the one being taken
						rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			open_q     <= 1'b0;
			start_q    <= '0;
			tmatch_q   <= '0;
			nbytes_q   <= '0;
			rd_ptr_q   <= '0;
			emit_idx_q <= '0;
			len_q      <= '0;
			long_q     <= 1'b0;
		end else begin
			if (in_acc) begin
				wp_q <= ptr_next(wp_q);
				if (open_q) begin
					nbytes_q <= nbytes_nx;
					if (close_hit) begin
						open_q     <= 1'b0;
						tmatch_q   <= '0;
						nbytes_q   <= '0;
						long_q     <= over;
						len_q      <= nbytes_nx - CW'(TAIL_BYTES);
						rd_ptr_q   <= start_q;
						emit_idx_q <= '0;
					end else if (tail_hit) begin
						tmatch_q <= tmatch_q + 1'b1;
					end else begin
						// drop the partial tail match; this byte is not rechecked
						tmatch_q <= '0;
					end
				end else if (rx_byte == head_byte_q) begin
					open_q   <= 1'b1;
					start_q  <= wp_q;
					tmatch_q <= '0;
					nbytes_q <= CW'(1);
				end
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (out_acc) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	// ring buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[wp_q] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_ptr_q];
		end
	end

	`ASSERT_SAME(a_emit_in_range, clk, arst_n, out_valid && !long_q, emit_idx_q < len_q)
	`ASSERT_NEXT(a_read_then_out, clk, arst_n, state_q == S_READ, out_valid)
	`ASSERT_NEXT(a_last_frees_input, clk, arst_n, out_acc && last_w, !out_valid && !in_stall)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the head/tail frame extractor and checks every
// emitted frame byte against a byte-level tracker of the ring, the open frame
// and the tail match. The run uses a short directed stream, then random phases
// under several head and tail settings, with random idling on both sides.
// ----------------------------------------------------------------------------

module testbench;

	import htfe_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int TAIL_LEN   = 4;
	localparam int PHASE_BYTES = 30;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int HOLDOFF_AT_RESULT = 150;

	// indexes past the register list; writes to them must have no effect
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] fbyte;
		logic              is_last;
		logic [LEN_W-1:0]  len;
		logic              overlong;
	} frame_out_t;

	class frame_tracker;
		logic [BYTE_W-1:0] ring [RING_DEPTH];
		logic [5:0]        wr_pos;
		logic              in_frame;
		logic [5:0]        start_pos;
		logic [2:0]        tail_hits;
		logic [LEN_W-1:0]  frame_count;
		logic [BYTE_W-1:0] head_val;
		logic [TAIL_W-1:0] tail_word;
		frame_out_t        expected_bytes [$];
		int                errors;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			wr_pos      = '0;
			in_frame    = 1'b0;
			start_pos   = '0;
			tail_hits   = '0;
			frame_count = '0;
			head_val    = HEAD_RESET;
			tail_word   = TAIL_RESET;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_HEAD_BYTE: head_val = data[BYTE_W-1:0];
				REG_TAIL_PATTERN: tail_word = data[TAIL_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// Advance the ring and frame state by one accepted request.
		function void take_rx_byte(logic [BYTE_W-1:0] rx);
			logic [BYTE_W-1:0] want;
			logic [5:0]        p;
			int                len;
			frame_out_t        r;
			ring[wr_pos] = rx;
			if (in_frame) begin
				if (frame_count <= RING_DEPTH)
					frame_count = frame_count + 1'b1;
				want = tail_word[8 * (TAIL_LEN - 1 - int'(tail_hits)) +: 8];
				if (rx == want) begin
					tail_hits = tail_hits + 1'b1;
					if (tail_hits >= TAIL_LEN) begin
						if (frame_count > RING_DEPTH) begin
							r = '{fbyte: '0, is_last: 1'b1, len: '0, overlong: 1'b1};
							expected_bytes.push_back(r);
						end else begin
							len = int'(frame_count) - TAIL_LEN;
							p = start_pos;
							for (int i = 0; i < len; i++) begin
								r.fbyte    = ring[p];
								r.is_last  = (i + 1 == len);
								r.len      = LEN_W'(len);
								r.overlong = 1'b0;
								expected_bytes.push_back(r);
								p = (p == RING_DEPTH - 1) ? 6'd0 : p + 1'b1;
							end
						end
						in_frame    = 1'b0;
						tail_hits   = '0;
						frame_count = '0;
					end
				end else begin
					// drop the partial tail; this byte is not retried as a first tail byte
					tail_hits = '0;
				end
			end else if (rx == head_val) begin
				in_frame    = 1'b1;
				start_pos   = wr_pos;
				tail_hits   = '0;
				frame_count = 7'd1;
			end
			wr_pos = (wr_pos == RING_DEPTH - 1) ? 6'd0 : wr_pos + 1'b1;
		endfunction

		function void check_frame_byte(logic [BYTE_W-1:0] fb, logic lst,
				logic [LEN_W-1:0] len, logic tl);
			frame_out_t want;
			if (expected_bytes.size() == 0) begin
				$error("unexpected result: frame_byte %0h last_of_frame %0b frame_length %0d too_long %0b",
					fb, lst, len, tl);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (fb !== want.fbyte) begin
				$error("frame_byte mismatch: expected %0h, actual %0h", want.fbyte, fb);
				errors++;
			end
			if (lst !== want.is_last) begin
				$error("last_of_frame mismatch: expected %0b, actual %0b", want.is_last, lst);
				errors++;
			end
			if (len !== want.len) begin
				$error("frame_length mismatch: expected %0d, actual %0d", want.len, len);
				errors++;
			end
			if (tl !== want.overlong) begin
				$error("too_long mismatch: expected %0b, actual %0b", want.overlong, tl);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [BYTE_W-1:0]    frame_byte;
	logic                 last_of_frame;
	logic [LEN_W-1:0]     frame_length;
	logic                 too_long;

	frame_tracker tracker;
	logic         idle_in;
	logic         idle_out;
	int           bytes_sent;
	int           results_seen;
	int           stall_left;
	int           holdoff_left;

	// reset config: noise, a plain frame, a head inside a frame, a broken tail
	logic [BYTE_W-1:0] opening_bytes [23] = '{
		8'h00, 8'hFF,
		8'h88, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55, 8'hAA,
		8'h88, 8'h88, 8'h55, 8'hAA, 8'h55, 8'hAA,
		8'h88, 8'h55, 8'hAA, 8'h00, 8'h55, 8'hAA, 8'h55, 8'hAA
	};

	head_tail_frame_extractor u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last_of_frame (last_of_frame),
		.frame_length  (frame_length),
		.too_long      (too_long)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_400_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: stall per result, plus one long hold-off.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				out_stall = 1'b1;
				holdoff_left--;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_frame_byte(frame_byte, last_of_frame, frame_length, too_long);
			results_seen++;
			stall_left = idle_out ? $urandom_range(0, 6) : 0;
			if (results_seen == HOLDOFF_AT_RESULT)
				holdoff_left = HOLDOFF_CYCLES;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = idle_in ? $urandom_range(0, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte  = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_rx_byte(b);
		bytes_sent++;
	endtask

	// Hold the sender until every expected byte is out and the block has settled.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.write_reg(idx, data);
	endtask

	task automatic run_phase(input int ph);
		int                stop_at;
		int                body_len;
		int                r;
		int                cut;
		bit                first;
		logic [BYTE_W-1:0] b;
		stop_at = bytes_sent + PHASE_BYTES;
		first   = 1'b1;
		while (bytes_sent < stop_at) begin
			repeat ($urandom_range(0, 3)) begin
				b = tracker.head_val;
				while (b == tracker.head_val)
					b = $urandom_range(0, 255);
				send_byte(b);
			end
			r = $urandom_range(0, 99);
			if (r < 80)
				body_len = $urandom_range(0, 12);
			else if (r < 88)
				body_len = RING_DEPTH - 1 - TAIL_LEN;
			else if (r < 95)
				body_len = $urandom_range(RING_DEPTH - TAIL_LEN, RING_DEPTH + 2);
			else
				body_len = $urandom_range(20, RING_DEPTH - 2 - TAIL_LEN);
			if (first) begin
				case (ph)
					1: body_len = RING_DEPTH - 1 - TAIL_LEN;
					2: body_len = RING_DEPTH - 2 - TAIL_LEN;
					3: body_len = RING_DEPTH - TAIL_LEN;
					5: body_len = RING_DEPTH + 6;
					default: ;
				endcase
			end
			first = 1'b0;
			send_byte(tracker.head_val);
			for (int i = 0; i < body_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 12)
					b = tracker.tail_word[8 * $urandom_range(0, TAIL_LEN - 1) +: 8];
				else if (r < 20)
					b = tracker.head_val;
				else
					b = $urandom_range(0, 255);
				send_byte(b);
			end
			// break the tail now and then: partial match, then a sure mismatch
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, TAIL_LEN - 1);
				for (int k = 0; k < cut; k++)
					send_byte(tracker.tail_word[8 * (TAIL_LEN - 1 - k) +: 8]);
				send_byte(~tracker.tail_word[8 * (TAIL_LEN - 1 - cut) +: 8]);
			end
			for (int k = 0; k < TAIL_LEN; k++)
				send_byte(tracker.tail_word[8 * (TAIL_LEN - 1 - k) +: 8]);
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] new_head;
		logic [TAIL_W-1:0] new_tail;
		tracker      = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		rx_byte      = '0;
		idle_in      = 1'b1;
		idle_out     = 1'b1;
		bytes_sent   = 0;
		results_seen = 0;
		stall_left   = 0;
		holdoff_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					new_head = 8'h00;
					new_tail = 32'h0000_0000;
				end
				1: begin
					new_head = 8'hFF;
					new_tail = 32'hFFFF_FFFF;
				end
				2: begin
					new_head = 8'h7E;
					new_tail = 32'h0D0A_0D0A;
				end
				4: begin
					new_head = HEAD_RESET;
					new_tail = TAIL_RESET;
				end
				6: begin
					// head equal to every tail byte
					new_head = 8'hA5;
					new_tail = 32'hA5A5_A5A5;
				end
				default: begin
					new_head = $urandom_range(0, 255);
					new_tail = $urandom;
				end
			endcase
			settle();
			if (ph == 0) begin
				write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
				write_reg(REG_SPARE_3, 32'h0000_0000);
			end else if (ph == 4) begin
				write_reg(REG_SPARE_2, $urandom);
				write_reg(REG_SPARE_3, $urandom);
			end
			write_reg(REG_HEAD_BYTE, {24'($urandom), new_head});
			write_reg(REG_TAIL_PATTERN, new_tail);
			idle_in  = (ph % 3 != 1);
			idle_out = (ph % 4 != 2);
			run_phase(ph);
		end

		settle();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/htfe_pkg.sv
rtl/core/head_tail_frame_extractor.sv
dv/testbench.sv
